/* hw/rtl/scfl_pkg.sv */
// Shared types, constants and helpers for the size class free list allocator.
// No dependencies.
package scfl_pkg;

  localparam int NUM_CLASSES     = 8;
  localparam int SLOTS_PER_CLASS = 16;

  localparam int CLASS_W   = $clog2(NUM_CLASSES);
  localparam int SLOT_W    = $clog2(SLOTS_PER_CLASS);
  localparam int LINK_W    = SLOT_W + 1;              // one more code for "none"
  localparam int LINK_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int LINK_AW   = CLASS_W + SLOT_W;
  localparam int SIZE_W    = 16;

  localparam logic [LINK_W-1:0] SLOT_NONE = LINK_W'(SLOTS_PER_CLASS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CLASS_W-1:0] size_class;
    logic [SLOT_W-1:0]  granted_slot;
  } rsp_t;

  typedef struct packed {
    logic               fits;
    logic [CLASS_W-1:0] cls;
  } class_sel_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Smallest class c with size <= 2^(c+1); independent compares, priority pick.
  function automatic class_sel_t class_of(input logic [SIZE_W-1:0] size);
    class_sel_t sel;
    logic [SIZE_W:0] limit;
    sel.fits = 1'b0;
    sel.cls  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      limit = (SIZE_W+1)'(1) << (c + 1);
      if ({1'b0, size} <= limit) begin
        sel.fits = 1'b1;
        sel.cls  = CLASS_W'(c);
      end
    end
    return sel;
  endfunction

endpackage

/* hw/rtl/scfl_link_mem.sv */
// Next-link memory for all class stacks, registered read.
// Per-entry valid bits stand in for the reset chain. Depends on scfl_pkg.
module scfl_link_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [scfl_pkg::LINK_AW-1:0] rd_addr,
  output logic [scfl_pkg::LINK_W-1:0]  rd_link,
  input  logic                         wr_en,
  input  logic [scfl_pkg::LINK_AW-1:0] wr_addr,
  input  logic [scfl_pkg::LINK_W-1:0]  wr_link
);
  import scfl_pkg::*;

  logic [LINK_W-1:0]     mem [LINK_DEPTH];
  logic [LINK_DEPTH-1:0] vld_r;
  logic [LINK_W-1:0]     rd_data_r;
  logic                  rd_vld_r;
  logic [LINK_W-1:0]     rd_dflt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_link;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Reset chain: slot i links to i+1, the last slot to none (i+1 == SLOTS).
  always_ff @(posedge clk) begin
    rd_dflt_r <= {1'b0, rd_addr[SLOT_W-1:0]} + LINK_W'(1);
  end

  assign rd_link = rd_vld_r ? rd_data_r : rd_dflt_r;

endmodule

/* hw/rtl/size_class_free_list_allocator.sv */
// Top level of the size class free list allocator.
// Depends on scfl_pkg and scfl_link_mem.
//
// One free stack of slots per power-of-two size class; class c hands out
// chunks of 2^(c+1) bytes. A request is taken when start is high and busy is
// low, and each request yields exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall it. In the accept cycle the block
// looks up the class stack head and launches the read of the link memory,
// and in the following cycle (busy high) it updates the head and the link
// memory and presents the result. The registered read of the link memory
// calls for that second step, so no new request is taken while busy. After
// reset the link memory needs no clearing pass: its entries read as the
// initial chain until written. Status is ok, pool empty (allocate from an
// empty class) or oversize (size above 2^NUM_CLASSES, on allocate or free).
// Double frees are not detected.
module size_class_free_list_allocator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  scfl_pkg::req_t in_req,
  output logic           out_valid,
  output scfl_pkg::rsp_t out_rsp
);
  import scfl_pkg::*;

  state_t state_r, state_nxt;

  // Head of each class stack; small, read at one address, kept in flops.
  logic [LINK_W-1:0] free_head_r [NUM_CLASSES];

  // Request latched at accept.
  logic               op_r;
  logic               fits_r;
  logic [CLASS_W-1:0] cls_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [LINK_W-1:0]  head_r;

  class_sel_t         sel;
  logic               accept;
  logic [LINK_W-1:0]  head_now;
  logic [LINK_W-1:0]  next_link;

  logic               pop_ok;
  logic               push_ok;

  assign accept   = start && (state_r == S_IDLE);
  assign sel      = class_of(in_req.request_size);
  assign head_now = free_head_r[sel.cls];

  // Link memory: read launched at accept, write in the execute cycle. Reads
  // and writes never overlap since no request is taken while busy.
  scfl_link_mem u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr ({sel.cls, head_now[SLOT_W-1:0]}),
    .rd_link (next_link),
    .wr_en   (push_ok),
    .wr_addr ({cls_r, slot_r}),
    .wr_link (head_r)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and update strobes.
  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    pop_ok    = 1'b0;
    push_ok   = 1'b0;
    out_rsp   = '0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_EXEC: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        if (!fits_r) begin
          out_rsp.status = ST_OVERSIZE;
        end else begin
          out_rsp.size_class = cls_r;
          if (op_r == OP_ALLOC) begin
            if (head_r >= SLOT_NONE) begin
              out_rsp.status = ST_EMPTY;
            end else begin
              out_rsp.status       = ST_OK;
              out_rsp.granted_slot = head_r[SLOT_W-1:0];
              pop_ok               = 1'b1;
            end
          end else begin
            // Slot width covers exactly the pool, so every freed slot is in range.
            out_rsp.status = ST_OK;
            push_ok        = 1'b1;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_req.opcode;
      fits_r <= sel.fits;
      cls_r  <= sel.cls;
      slot_r <= in_req.slot_index;
      head_r <= head_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_head_r[c] <= '0;
      end
    end else if (pop_ok) begin
      free_head_r[cls_r] <= next_link;
    end else if (push_ok) begin
      free_head_r[cls_r] <= {1'b0, slot_r};
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && out_valid)
    else $error("accepted request did not reach execute");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute lasted more than one cycle");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_oversize_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_OVERSIZE |->
      out_rsp.size_class == '0 && out_rsp.granted_slot == '0)
    else $error("oversize result carries class or slot");

  a_no_update_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !pop_ok && !push_ok)
    else $error("state update outside execute");
`endif

endmodule

/* bench/scfl_checker.sv */
// Checker for the size class free list allocator: watches the request and
// result channels, predicts each response and compares it field by field.
// Depends on scfl_pkg.
`timescale 1ns / 100ps

module scfl_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  scfl_pkg::req_t in_req,
  input  logic           out_valid,
  input  scfl_pkg::rsp_t out_rsp,
  output int             fail_count,
  output int             pending,
  output int             ok_count,
  output int             empty_count,
  output int             oversize_count
);
  import scfl_pkg::*;

  // Predicted stack state: head of each class and the slot below each slot.
  logic [LINK_W-1:0] stack_top [NUM_CLASSES];
  logic [LINK_W-1:0] slot_below [NUM_CLASSES][SLOTS_PER_CLASS];
  rsp_t              expected_rsps [$];
  rsp_t              want;

  task automatic chain_all_slots();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      stack_top[c] = '0;
      for (int s = 0; s < SLOTS_PER_CLASS; s++) begin
        slot_below[c][s] = LINK_W'(s + 1);
      end
    end
  endtask

  // Works out the response to one request and updates the predicted stacks.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t               rsp;
    logic               fits;
    logic [CLASS_W-1:0] cls;
    logic [SLOT_W-1:0]  top_slot;
    fits = 1'b0;
    cls  = '0;
    for (int c = 0; c < NUM_CLASSES && !fits; c++) begin
      if (32'(r.request_size) <= (32'd1 << (c + 1))) begin
        fits = 1'b1;
        cls  = CLASS_W'(c);
      end
    end
    rsp.status       = ST_OK;
    rsp.size_class   = '0;
    rsp.granted_slot = '0;
    if (!fits) begin
      rsp.status = ST_OVERSIZE;
    end else begin
      rsp.size_class = cls;
      if (r.opcode == OP_ALLOC) begin
        if (stack_top[cls] >= SLOT_NONE) begin
          rsp.status = ST_EMPTY;
        end else begin
          top_slot         = stack_top[cls][SLOT_W-1:0];
          rsp.granted_slot = top_slot;
          stack_top[cls]   = slot_below[cls][top_slot];
        end
      end else if (32'(r.slot_index) < SLOTS_PER_CLASS) begin
        slot_below[cls][r.slot_index] = stack_top[cls];
        stack_top[cls]                = LINK_W'(r.slot_index);
      end
    end
    return rsp;
  endfunction

  initial chain_all_slots();

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_all_slots();
      expected_rsps.delete();
    end else begin
      if (out_valid) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding: %p", out_rsp);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_rsp.status);
            fail_count++;
          end
          if (out_rsp.size_class !== want.size_class) begin
            $error("size_class mismatch: expected %0d, got %0d",
                   want.size_class, out_rsp.size_class);
            fail_count++;
          end
          if (out_rsp.granted_slot !== want.granted_slot) begin
            $error("granted_slot mismatch: expected %0d, got %0d",
                   want.granted_slot, out_rsp.granted_slot);
            fail_count++;
          end
          case (want.status)
            ST_OK:    ok_count++;
            ST_EMPTY: empty_count++;
            default:  oversize_count++;
          endcase
        end
      end
      if (start && !busy) begin
        expected_rsps.push_back(serve_request(in_req));
      end
    end
    pending <= expected_rsps.size();
  end

endmodule

/* bench/size_class_free_list_allocator_test.sv */
// Testbench top for the size class free list allocator: clock, reset,
// directed and random request stimulus, and the final verdict.
// Depends on scfl_pkg, scfl_checker and the allocator RTL.
`timescale 1ns / 100ps

module size_class_free_list_allocator_test;
  import scfl_pkg::*;

  localparam int REQ_W       = $bits(req_t);
  localparam int CYCLE_LIMIT = 200000;   // a correct run ends well before this limit
  localparam int PHASE_ITEMS = 300;      // four phases, about 1200 random requests

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SLOT_W-1:0]  slot;
  } chunk_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  int fail_count;
  int pending;
  int ok_count;
  int empty_count;
  int oversize_count;
  int cycle_count;
  int sent_count;
  int directed_count;

  // Chunks the block has granted and that we have not yet freed again;
  // frees are mostly drawn from here so the stacks see realistic traffic.
  chunk_t live_chunks [$];
  logic   issued_ops [$];
  logic   done_op;

  // Idle percentage per phase; the receiver cannot stall, so the phases
  // that would stall it run with a busy sender instead.
  int idle_pct [4]  = '{0, 58, 0, 34};
  // Share of allocates per phase: heavy allocation drains pools to empty,
  // light allocation refills them.
  int alloc_pct [4] = '{85, 45, 70, 30};

  always #5 clk = ~clk;

  size_class_free_list_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  scfl_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_rsp        (out_rsp),
    .fail_count     (fail_count),
    .pending        (pending),
    .ok_count       (ok_count),
    .empty_count    (empty_count),
    .oversize_count (oversize_count)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** size_class_free_list_allocator: FAILED **");
      $finish;
    end
  end

  // Track grants so later frees can return real chunks. One result comes
  // back per request, in order, so a queue of opcodes pairs them up.
  always @(posedge clk) begin
    if (rst_n && out_valid && issued_ops.size() > 0) begin
      done_op = issued_ops.pop_front();
      if (done_op == OP_ALLOC && out_rsp.status == ST_OK) begin
        live_chunks.push_back('{cls: out_rsp.size_class, slot: out_rsp.granted_slot});
      end
    end
    if (rst_n && start && !busy) begin
      issued_ops.push_back(in_req.opcode);
    end
  end

  // A byte size that maps to class c: class 0 takes 0..2, class c > 0
  // takes 2^c+1 .. 2^(c+1).
  function automatic logic [SIZE_W-1:0] size_in_class(input int c);
    if (c == 0) begin
      return SIZE_W'($urandom_range(2));
    end
    return SIZE_W'($urandom_range(1 << (c + 1), (1 << c) + 1));
  endfunction

  function automatic req_t make_req(input logic op, input int size, input int slot);
    req_t r;
    r.opcode       = op;
    r.request_size = SIZE_W'(size);
    r.slot_index   = SLOT_W'(slot);
    return r;
  endfunction

  // Random request: mostly in-range sizes, a few raw 16-bit sizes (mostly
  // oversize), and frees that usually return a chunk that is really out.
  function automatic req_t random_request(input int alloc_share);
    req_t r;
    int   pick;
    int   idx;
    r.opcode       = ($urandom_range(99) < alloc_share) ? OP_ALLOC : OP_FREE;
    r.slot_index   = SLOT_W'($urandom);
    r.request_size = size_in_class($urandom_range(NUM_CLASSES - 1));
    pick           = $urandom_range(99);
    if (pick < 6) begin
      r.request_size = SIZE_W'($urandom);
    end else if (r.opcode == OP_FREE && pick < 90 && live_chunks.size() > 0) begin
      // Well-formed free; the remaining frees are noise and double frees.
      idx            = $urandom_range(live_chunks.size() - 1);
      r.request_size = size_in_class(live_chunks[idx].cls);
      r.slot_index   = live_chunks[idx].slot;
      live_chunks.delete(idx);
    end
    return r;
  endfunction

  // Holds start high until the request is taken (start high, busy low at
  // an edge). Idle cycles before it put junk on the bus with start low.
  task automatic send_request(input req_t r, input int idle_share);
    while ($urandom_range(99) < idle_share) begin
      start  <= 1'b0;
      in_req <= req_t'(REQ_W'($urandom));
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    req_t directed [$];
    start  = 1'b0;
    in_req = '0;
    rst_n  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: class boundaries, oversize on both opcodes, the top slot,
    // and a double free that makes the class 0 chain loop on itself.
    directed.push_back(make_req(OP_ALLOC, 0, 9));
    directed.push_back(make_req(OP_ALLOC, 1, 0));
    directed.push_back(make_req(OP_ALLOC, 2, 15));
    directed.push_back(make_req(OP_ALLOC, 3, 0));
    directed.push_back(make_req(OP_ALLOC, 4, 0));
    directed.push_back(make_req(OP_ALLOC, 5, 0));
    directed.push_back(make_req(OP_ALLOC, 16, 0));
    directed.push_back(make_req(OP_ALLOC, 128, 0));
    directed.push_back(make_req(OP_ALLOC, 129, 0));
    directed.push_back(make_req(OP_ALLOC, 256, 0));
    directed.push_back(make_req(OP_ALLOC, 257, 0));
    directed.push_back(make_req(OP_ALLOC, 65535, 15));
    directed.push_back(make_req(OP_FREE, 257, 3));
    directed.push_back(make_req(OP_FREE, 65535, 15));
    directed.push_back(make_req(OP_FREE, 32768, 0));
    directed.push_back(make_req(OP_FREE, 1, 1));
    directed.push_back(make_req(OP_FREE, 0, 1));
    directed.push_back(make_req(OP_ALLOC, 2, 0));
    directed.push_back(make_req(OP_ALLOC, 1, 0));
    directed.push_back(make_req(OP_FREE, 4, 15));
    directed.push_back(make_req(OP_ALLOC, 3, 0));
    directed.push_back(make_req(OP_FREE, 200, 0));
    directed.push_back(make_req(OP_ALLOC, 255, 0));
    foreach (directed[i]) send_request(directed[i], 0);
    directed_count = sent_count;

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(alloc_pct[ph]), idle_pct[ph]);
      end
    end
    start  <= 1'b0;
    in_req <= '0;

    // Drain: wait for every expected response, then a few cycles more in
    // case the block emits something unexpected.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (pending != 0) begin
      $error("%0d expected responses never arrived", pending);
    end
    $display("Sent %0d requests (%0d directed) over four idle and allocation mixes.",
             sent_count, directed_count);
    $display("Checked responses: %0d ok, %0d pool empty, %0d oversize.",
             ok_count, empty_count, oversize_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** size_class_free_list_allocator: PASSED **");
    end else begin
      $display("** size_class_free_list_allocator: FAILED **");
    end
    $finish;
  end

endmodule
